### rtl/rde_pkg.sv
// shared constants and helper functions for the radix digit emitter
package rde_pkg;

	localparam int RADIX_W    = 5;
	localparam int DIGIT_W    = 4;
	localparam int CHAR_W     = 7;
	localparam int COUNT_W    = 7;
	localparam int MAX_DIGITS = 64;
	localparam int PTR_W      = 6;

	localparam logic [RADIX_W-1:0] RADIX_MIN     = 5'd2;
	localparam logic [RADIX_W-1:0] RADIX_MAX     = 5'd16;
	localparam logic [DIGIT_W-1:0] DECIMAL_SPLIT = 4'd10;
	localparam logic [CHAR_W-1:0]  CHAR_ZERO     = 7'd48;
	localparam logic [CHAR_W-1:0]  CHAR_UPPER_A  = 7'd65;

	// clamp a radix code to the supported 2..16 range
	function automatic logic [RADIX_W-1:0] sat_radix(input logic [RADIX_W-1:0] r);
		logic [RADIX_W-1:0] res;
		if (r < RADIX_MIN) begin
			res = RADIX_MIN;
		end else if (r > RADIX_MAX) begin
			res = RADIX_MAX;
		end else begin
			res = r;
		end
		return res;
	endfunction

	// map a digit value to its ascii character
	function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
		logic [CHAR_W-1:0] res;
		if (d < DECIMAL_SPLIT) begin
			res = CHAR_ZERO + CHAR_W'(d);
		end else begin
			res = CHAR_UPPER_A + CHAR_W'(d - DECIMAL_SPLIT);
		end
		return res;
	endfunction

endpackage

### rtl/rde_divider.sv
// iterative divider: splits a value by a small radix, eight quotient bits per cycle
module rde_divider
	import rde_pkg::*;
#(
	parameter int VALUE_BITS = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [VALUE_BITS-1:0] dividend,
	input  logic [RADIX_W-1:0]    radix,
	output logic                  done,
	output logic [VALUE_BITS-1:0] quotient,
	output logic [DIGIT_W-1:0]    remainder
);

	localparam int CHUNKS = (VALUE_BITS + 7) / 8;
	localparam int PAD_W  = CHUNKS * 8;
	localparam int STEP_W = $clog2(CHUNKS + 1);

	logic [PAD_W-1:0]   dvd_q;
	logic [DIGIT_W-1:0] rem_q;
	logic [RADIX_W-1:0] radix_q;
	logic [STEP_W-1:0]  step_q;
	logic               busy_q;
	logic               done_q;

	logic [7:0]         qbits;
	logic [DIGIT_W-1:0] rem_d;
	logic [7:0]         top_bits;

	assign top_bits = dvd_q[PAD_W-1 -: 8];

	// eight restoring steps on the narrow partial remainder
	always_comb begin
		logic [DIGIT_W:0]   t;
		logic [DIGIT_W-1:0] r;
		r = rem_q;
		qbits = '0;
		for (int i = 7; i >= 0; i--) begin
			t = {r, top_bits[i]};
			if (t >= radix_q) begin
				t = t - radix_q;
				qbits[i] = 1'b1;
			end
			r = t[DIGIT_W-1:0];
		end
		rem_d = r;
	end

	// control: step counter and done pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= busy_q && (step_q == STEP_W'(1));
			if (start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(CHUNKS);
			end else if (busy_q) begin
				step_q <= step_q - STEP_W'(1);
				if (step_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// datapath: dividend shifts out at the top, quotient bits shift in below
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q   <= PAD_W'(dividend);
			rem_q   <= '0;
			radix_q <= radix;
		end else if (busy_q) begin
			dvd_q <= (dvd_q << 8) | PAD_W'(qbits);
			rem_q <= rem_d;
		end
	end

	assign done      = done_q;
	assign quotient  = dvd_q[VALUE_BITS-1:0];
	assign remainder = rem_q;

endmodule

### rtl/rde_digit_stack.sv
// digit store: written least significant first, read back in reverse order
module rde_digit_stack
	import rde_pkg::*;
(
	input  logic               clk,
	input  logic               wr_en,
	input  logic [PTR_W-1:0]   wr_addr,
	input  logic [DIGIT_W-1:0] wr_data,
	input  logic [PTR_W-1:0]   rd_addr,
	output logic [DIGIT_W-1:0] rd_data
);

	logic [DIGIT_W-1:0] mem [MAX_DIGITS];
	logic [DIGIT_W-1:0] rd_data_q;

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rd_data_q <= mem[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

### rtl/radix_digit_emitter_top.sv
// radix digit emitter: converts one value to ascii digits, most significant first
// each digit comes from the shared divider as a remainder; once all digits are stored,
// each is read back from the digit store, most significant first
// one item at a time: item_stall stays high until the last digit is loaded into the output register
// reset clears the sequencer and output valid; payload registers are not reset
module radix_digit_emitter_top
	import rde_pkg::*;
#(
	parameter int VALUE_BITS = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  logic [63:0]        value,
	input  logic [RADIX_W-1:0] radix,
	output logic               digit_valid,
	input  logic               digit_stall,
	output logic [CHAR_W-1:0]  digit_char,
	output logic               is_last,
	output logic [COUNT_W-1:0] digit_count
);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_DIV  = 4'b0010,
		ST_RD   = 4'b0100,
		ST_OUT  = 4'b1000
	} state_t;

	state_t              state_q;
	logic [RADIX_W-1:0]  radix_q;
	logic [COUNT_W-1:0]  count_q;
	logic [PTR_W-1:0]    ptr_q;
	logic                out_valid_q;
	logic [CHAR_W-1:0]   out_char_q;
	logic                out_last_q;
	logic [COUNT_W-1:0]  out_count_q;

	logic                  accept;
	logic                  div_start;
	logic                  div_done;
	logic [VALUE_BITS-1:0] div_dividend;
	logic [RADIX_W-1:0]    div_radix;
	logic [VALUE_BITS-1:0] div_quot;
	logic [DIGIT_W-1:0]    div_rem;
	logic [COUNT_W-1:0]    count_next;
	logic                  conv_end;
	logic                  out_free;
	logic [DIGIT_W-1:0]    rd_digit;

	assign item_stall = (state_q != ST_IDLE);
	assign accept     = item_valid && (state_q == ST_IDLE);

	// divider operands: fresh word on accept, otherwise the last quotient
	assign count_next   = count_q + COUNT_W'(1);
	assign conv_end     = (div_quot == '0) || (count_next == COUNT_W'(MAX_DIGITS));
	assign div_start    = accept || ((state_q == ST_DIV) && div_done && !conv_end);
	assign div_dividend = (state_q == ST_IDLE) ? value[VALUE_BITS-1:0] : div_quot;
	assign div_radix    = (state_q == ST_IDLE) ? sat_radix(radix) : radix_q;

	rde_divider #(
		.VALUE_BITS(VALUE_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.radix    (div_radix),
		.done     (div_done),
		.quotient (div_quot),
		.remainder(div_rem)
	);

	rde_digit_stack u_stack (
		.clk    (clk),
		.wr_en  ((state_q == ST_DIV) && div_done),
		.wr_addr(count_q[PTR_W-1:0]),
		.wr_data(div_rem),
		.rd_addr(ptr_q),
		.rd_data(rd_digit)
	);

	assign out_free = !out_valid_q || !digit_stall;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			ptr_q   <= '0;
			radix_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						radix_q <= sat_radix(radix);
						count_q <= '0;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						count_q <= count_next;
						if (conv_end) begin
							ptr_q   <= count_q[PTR_W-1:0];
							state_q <= ST_RD;
						end
					end
				end
				ST_RD: begin
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_free) begin
						if (ptr_q == '0) begin
							state_q <= ST_IDLE;
						end else begin
							ptr_q   <= ptr_q - PTR_W'(1);
							state_q <= ST_RD;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_OUT) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!digit_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_OUT) && out_free) begin
			out_char_q  <= digit_to_ascii(rd_digit);
			out_last_q  <= (ptr_q == '0);
			out_count_q <= (ptr_q == '0) ? count_q : '0;
		end
	end

	assign digit_valid = out_valid_q;
	assign digit_char  = out_char_q;
	assign is_last     = out_last_q;
	assign digit_count = out_count_q;

endmodule

### tb/sv/tb_top.sv
// testbench for radix_digit_emitter_top: directed and random words checked against a digit predictor
module tb_top;
	import rde_pkg::*;

	localparam int VALUE_BITS  = 64;
	localparam int STUCK_LIMIT = 5000;
	localparam int DRAIN_TAIL  = 40;
	localparam int RANDOM_WORDS = 408;
	localparam logic [63:0] VALUE_MASK = (VALUE_BITS >= 64) ? '1 : ((64'd1 << VALUE_BITS) - 64'd1);

	typedef struct packed {
		logic [CHAR_W-1:0]  ch;
		logic               last;
		logic [COUNT_W-1:0] count;
	} digit_word_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               item_valid = 1'b0;
	logic               item_stall;
	logic [63:0]        value = '0;
	logic [RADIX_W-1:0] radix = '0;
	logic               digit_valid;
	logic               digit_stall = 1'b0;
	logic [CHAR_W-1:0]  digit_char;
	logic               is_last;
	logic [COUNT_W-1:0] digit_count;

	digit_word_t pending_digits[$];
	int          mismatch_count = 0;
	int          stuck_cycles = 0;
	int          rx_hold = 0;
	int          rx_calm = 0;
	bit          tx_calm = 1'b0;

	radix_digit_emitter_top #(
		.VALUE_BITS(VALUE_BITS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.value(value),
		.radix(radix),
		.digit_valid(digit_valid),
		.digit_stall(digit_stall),
		.digit_char(digit_char),
		.is_last(is_last),
		.digit_count(digit_count)
	);

	// clock
	initial begin
		forever #2 clk = ~clk;
	end

	// idle length: mostly short, now and then long
	function automatic int gap_len();
		int n;
		if ($urandom_range(0, 9) == 0) begin
			n = $urandom_range(12, 40);
		end else begin
			n = $urandom_range(1, 3);
		end
		return n;
	endfunction

	// expected digits of one word, most significant first
	function automatic void predict_digits(input logic [63:0] v_in, input logic [RADIX_W-1:0] r_in);
		logic [63:0]        v;
		logic [63:0]        base;
		logic [63:0]        rem;
		logic [CHAR_W-1:0]  rev[MAX_DIGITS];
		digit_word_t        w;
		int                 n;
		bit                 more;
		v = v_in & VALUE_MASK;
		if (r_in < 5'd2) begin
			base = 64'd2;
		end else if (r_in > 5'd16) begin
			base = 64'd16;
		end else begin
			base = 64'(r_in);
		end
		n = 0;
		more = 1'b1;
		while (more) begin
			rem = v % base;
			if (rem < 64'(DECIMAL_SPLIT)) begin
				rev[n] = CHAR_ZERO + CHAR_W'(rem);
			end else begin
				rev[n] = CHAR_UPPER_A + CHAR_W'(rem - 64'(DECIMAL_SPLIT));
			end
			n++;
			v = v / base;
			more = (v != 64'd0) && (n < MAX_DIGITS);
		end
		for (int k = 0; k < n; k++) begin
			w.ch    = rev[n - 1 - k];
			w.last  = (k == n - 1);
			w.count = w.last ? COUNT_W'(n) : '0;
			pending_digits.push_back(w);
		end
	endfunction

	// present one word and hold it until taken
	task automatic send_word(input logic [63:0] v, input logic [RADIX_W-1:0] r);
		int gap;
		gap = (tx_calm || $urandom_range(0, 1) == 0) ? 0 : gap_len();
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		value      <= v;
		radix      <= r;
		@(negedge clk);
		while (item_stall) @(negedge clk);
		predict_digits(v, r);
		@(posedge clk);
	endtask

	function automatic logic [63:0] random_value();
		logic [63:0] v;
		int          width;
		v = {$urandom, $urandom};
		case ($urandom_range(0, 9))
			0: begin
				v = '0;
			end
			1: begin
				v = '1;
			end
			2, 3, 4: begin
			end
			default: begin
				width = $urandom_range(1, 63);
				v = v & ((64'd1 << width) - 64'd1);
			end
		endcase
		return v;
	endfunction

	function automatic logic [RADIX_W-1:0] random_radix();
		logic [RADIX_W-1:0] r;
		case ($urandom_range(0, 9))
			0: begin
				r = RADIX_W'($urandom_range(0, 31));
			end
			1: begin
				r = 5'd2;
			end
			default: begin
				r = RADIX_W'($urandom_range(2, 16));
			end
		endcase
		return r;
	endfunction

	task automatic log_mismatch(input string msg);
		mismatch_count++;
		if (mismatch_count <= 10) begin
			$display("%s", msg);
		end
	endtask

	// receiver stall pattern, with calm stretches
	always @(posedge clk) begin : rx_stall_gen
		int pick;
		if (rx_calm > 0) begin
			rx_calm = rx_calm - 1;
			digit_stall <= 1'b0;
		end else if (rx_hold > 0) begin
			rx_hold = rx_hold - 1;
			digit_stall <= 1'b1;
		end else begin
			digit_stall <= 1'b0;
			pick = $urandom_range(0, 99);
			if (pick < 2) begin
				rx_calm = $urandom_range(50, 300);
			end else if (pick < 30) begin
				rx_hold = gap_len();
			end
		end
	end

	// compare each digit word taken from the block with the oldest prediction
	always @(negedge clk) begin : digit_check
		digit_word_t want;
		if (arst_n && digit_valid && !digit_stall) begin
			if (pending_digits.size() == 0) begin
				log_mismatch($sformatf("unexpected word: char %0d last %0d count %0d",
					digit_char, is_last, digit_count));
			end else begin
				want = pending_digits.pop_front();
				if (want.ch !== digit_char || want.last !== is_last || want.count !== digit_count) begin
					log_mismatch($sformatf("mismatch: char exp %0d got %0d, last exp %0d got %0d, count exp %0d got %0d",
						want.ch, digit_char, want.last, is_last, want.count, digit_count));
				end
			end
		end
	end

	// watchdog on cycles with no word moving on either side
	always @(negedge clk) begin
		if ((item_valid && !item_stall) || (digit_valid && !digit_stall)) begin
			stuck_cycles = 0;
		end else begin
			stuck_cycles = stuck_cycles + 1;
			if (stuck_cycles >= STUCK_LIMIT) begin
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	// zero gives a single '0'
	task automatic test_zero_value();
		send_word(64'd0, 5'd2);
		send_word(64'd0, 5'd10);
		send_word(64'd0, 5'd16);
	endtask

	// radix codes outside 2..16 clamp to the nearest bound
	task automatic test_radix_clamp();
		send_word(64'hFF, 5'd0);
		send_word(64'hFF, 5'd1);
		send_word(64'hFF, 5'd17);
		send_word(64'hFF, 5'd31);
		send_word('1, 5'd0);
		send_word('1, 5'd31);
	endtask

	// full-width values, including the longest run of 64 digits
	task automatic test_full_width();
		send_word('1, 5'd2);
		send_word('1, 5'd3);
		send_word('1, 5'd10);
		send_word('1, 5'd16);
	endtask

	// every hex digit and letter appears
	task automatic test_letter_digits();
		send_word(64'hFEDCBA9876543210, 5'd16);
		send_word(64'h0123456789ABCDEF, 5'd16);
	endtask

	// values on either side of a change in digit count
	task automatic test_digit_boundaries();
		send_word(64'h8000000000000000, 5'd2);
		send_word(64'd10000000000000000000, 5'd10);
		send_word(64'd9999999999999999999, 5'd10);
		send_word(64'd9, 5'd10);
		send_word(64'd10, 5'd10);
		send_word(64'd15, 5'd16);
		send_word(64'd16, 5'd16);
	endtask

	task automatic test_random_words();
		for (int i = 0; i < RANDOM_WORDS; i++) begin
			if (i % 40 == 0) begin
				tx_calm = (i % 80 == 0);
			end
			send_word(random_value(), random_radix());
		end
		tx_calm = 1'b0;
	endtask

	// stimulus, drain and verdict
	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_zero_value();
		test_radix_clamp();
		test_full_width();
		test_letter_digits();
		test_digit_boundaries();
		test_random_words();
		item_valid <= 1'b0;
		while (pending_digits.size() != 0) @(posedge clk);
		repeat (DRAIN_TAIL) @(posedge clk);
		if (mismatch_count == 0 && pending_digits.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
